/* sv/lidar_rect_zone_alarm_top_assert.svh */
// Assertion macros shared by the zone alarm checker.
`ifndef LIDAR_RECT_ZONE_ALARM_TOP_ASSERT_SVH
`define LIDAR_RECT_ZONE_ALARM_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LRZA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lrza: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LRZA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lrza: next-cycle check failed");

`endif

/* sv/lrza_pkg.sv */
// Shared types, constants and the sine table builder for the zone alarm.
package lrza_pkg;

  localparam int RANGE_W = 16;
  localparam int BEAM_W  = 10;
  localparam int LIMIT_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [RANGE_W-1:0] RANGE_NO_RETURN = '1;

  // pi in Q2.30
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_WIDTH     = 3'd0,
    REG_DEPTH          = 3'd1,
    REG_INDEX_RIGHT    = 3'd2,
    REG_INDEX_TOP_RIGHT = 3'd3,
    REG_INDEX_TOP_LEFT = 3'd4,
    REG_INDEX_LEFT     = 3'd5
  } cfg_reg_t;

  localparam logic [LIMIT_W-1:0] HALF_WIDTH_RST = 16'd500;
  localparam logic [LIMIT_W-1:0] DEPTH_RST      = 16'd2000;

  typedef struct packed {
    logic [LIMIT_W-1:0] half_width_mm;
    logic [LIMIT_W-1:0] depth_mm;
    logic [BEAM_W-1:0]  index_right;
    logic [BEAM_W-1:0]  index_top_right;
    logic [BEAM_W-1:0]  index_top_left;
    logic [BEAM_W-1:0]  index_left;
  } zone_cfg_t;

  // Beam after index decode, waiting for its table value.
  typedef struct packed {
    logic [RANGE_W-1:0] range_mm;
    logic [LIMIT_W-1:0] limit_mm;
    logic               check;
    logic               last;
  } beam_stage_t;

  // Two truncating Q2.30 products: term * x * x.
  function automatic logic [63:0] sq_step(input logic [63:0] term, input logic [63:0] x);
    logic [63:0] t;
    t = (term * x) >> 30;
    t = (t * x) >> 30;
    return t;
  endfunction

  // Taylor sine of x (Q2.30), rounded half up to frac_bits, saturated.
  function automatic logic [31:0] sine_from_x(input logic [63:0] x, input int frac_bits);
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        val;
    logic [63:0]        maxv;
    term = x;
    sum  = signed'(x);
    term = sq_step(term, x) / 64'd6;   sum = sum - signed'(term);
    term = sq_step(term, x) / 64'd20;  sum = sum + signed'(term);
    term = sq_step(term, x) / 64'd42;  sum = sum - signed'(term);
    term = sq_step(term, x) / 64'd72;  sum = sum + signed'(term);
    term = sq_step(term, x) / 64'd110; sum = sum - signed'(term);
    term = sq_step(term, x) / 64'd156; sum = sum + signed'(term);
    term = sq_step(term, x) / 64'd210; sum = sum - signed'(term);
    term = sq_step(term, x) / 64'd272; sum = sum + signed'(term);
    term = sq_step(term, x) / 64'd342; sum = sum - signed'(term);
    term = sq_step(term, x) / 64'd420; sum = sum + signed'(term);
    term = sq_step(term, x) / 64'd506; sum = sum - signed'(term);
    term = sq_step(term, x) / 64'd600; sum = sum + signed'(term);
    if (sum < 0) begin
      sum = '0;
    end
    val  = (unsigned'(sum) + (64'd1 << (29 - frac_bits))) >> (30 - frac_bits);
    maxv = (64'd1 << frac_bits) - 64'd1;
    if (val > maxv) begin
      val = maxv;
    end
    return val[31:0];
  endfunction

endpackage

/* sv/lrza_if.sv */
// Channel interfaces: beam samples in, scan results out, register writes.
interface lrza_beam_if;
  import lrza_pkg::*;
  logic               valid;
  logic               ready;
  logic [RANGE_W-1:0] range_mm;
  logic [BEAM_W-1:0]  beam_index;
  logic               last_of_scan;
  modport source (output valid, range_mm, beam_index, last_of_scan, input ready);
  modport sink   (input valid, range_mm, beam_index, last_of_scan, output ready);
endinterface

interface lrza_result_if;
  logic valid;
  logic ready;
  logic alarm;
  logic estop_request;
  logic clear_request;
  modport source (output valid, alarm, estop_request, clear_request, input ready);
  modport sink   (input valid, alarm, estop_request, clear_request, output ready);
endinterface

interface lrza_cfg_if;
  import lrza_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/lidar_rect_zone_alarm_top.sv */
// Rectangular lidar protective zone alarm, top level.
// in_beam: one range sample per transaction with its beam index and an
// end-of-scan mark. A beam in [index_right, index_left] blocks when its
// range times |cos| (side regions) or |sin| (middle region) of the beam
// angle is at most the half width or depth.
// out_result: one transaction per scan, issued for the beam marked last:
// alarm plus one-shot estop and clear requests on the alarm's edges.
// cfg_wr: register writes (index, data), always ready; write while idle.
// Throughput: one beam per cycle unless a last beam waits on a stalled
// out_result. The scan result reaches out_result through the
// input register, the registered sine table read and the result register.
// Reset: registers return to their defaults, scan state and previous alarm
// clear, all stages empty.
// Output stall: beams not ending a scan keep draining; a last beam waits
// in front of the result register, and at most one more beam is taken
// before in_beam.ready drops.
module lidar_rect_zone_alarm_top #(
  parameter int MAX_BEAMS       = 1024,
  parameter int HALF_TURN_STEPS = 512,
  parameter int TRIG_FRAC_BITS  = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  lrza_beam_if.sink     in_beam,
  lrza_result_if.source out_result,
  lrza_cfg_if.sink      cfg_wr
);
  import lrza_pkg::*;

  zone_cfg_t                 zone_cfg;
  logic                      stg_valid;
  beam_stage_t               stg;
  logic [TRIG_FRAC_BITS-1:0] stg_trig;
  logic                      stg_take;

  lrza_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr   (cfg_wr),
    .zone_cfg (zone_cfg)
  );

  lrza_front #(
    .MAX_BEAMS       (MAX_BEAMS),
    .HALF_TURN_STEPS (HALF_TURN_STEPS),
    .TRIG_FRAC_BITS  (TRIG_FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_beam   (in_beam),
    .zone_cfg  (zone_cfg),
    .stg_valid (stg_valid),
    .stg       (stg),
    .stg_trig  (stg_trig),
    .stg_take  (stg_take)
  );

  lrza_judge #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_judge (
    .clk        (clk),
    .rst_n      (rst_n),
    .stg_valid  (stg_valid),
    .stg        (stg),
    .stg_trig   (stg_trig),
    .stg_take   (stg_take),
    .out_result (out_result)
  );

endmodule

/* sv/lrza_cfg_regs.sv */
// Zone configuration registers behind the write channel.
module lrza_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  lrza_cfg_if.sink           cfg_wr,
  output lrza_pkg::zone_cfg_t zone_cfg
);
  import lrza_pkg::*;

  zone_cfg_t cfg_r;
  zone_cfg_t cfg_nxt;

  assign cfg_wr.ready = 1'b1;
  assign zone_cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        REG_HALF_WIDTH:      cfg_nxt.half_width_mm   = cfg_wr.data;
        REG_DEPTH:           cfg_nxt.depth_mm        = cfg_wr.data;
        REG_INDEX_RIGHT:     cfg_nxt.index_right     = cfg_wr.data[BEAM_W-1:0];
        REG_INDEX_TOP_RIGHT: cfg_nxt.index_top_right = cfg_wr.data[BEAM_W-1:0];
        REG_INDEX_TOP_LEFT:  cfg_nxt.index_top_left  = cfg_wr.data[BEAM_W-1:0];
        REG_INDEX_LEFT:      cfg_nxt.index_left      = cfg_wr.data[BEAM_W-1:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_width_mm   <= HALF_WIDTH_RST;
      cfg_r.depth_mm        <= DEPTH_RST;
      cfg_r.index_right     <= '0;
      cfg_r.index_top_right <= '0;
      cfg_r.index_top_left  <= '0;
      cfg_r.index_left      <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* sv/lrza_front.sv */
// Input register, beam angle decode and registered sine table read.
module lrza_front #(
  parameter int MAX_BEAMS       = 1024,
  parameter int HALF_TURN_STEPS = 512,
  parameter int TRIG_FRAC_BITS  = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  lrza_beam_if.sink                 in_beam,
  input  lrza_pkg::zone_cfg_t       zone_cfg,
  output logic                      stg_valid,
  output lrza_pkg::beam_stage_t     stg,
  output logic [TRIG_FRAC_BITS-1:0] stg_trig,
  input  logic                      stg_take
);
  import lrza_pkg::*;

  localparam int ADDR_W = $clog2(HALF_TURN_STEPS + 1);
  localparam int LOG_H  = $clog2(HALF_TURN_STEPS + 1) - 1;
  // quotient bits of a beam offset divided by the half turn
  localparam int MOD_STEPS = (BEAM_W > LOG_H) ? BEAM_W - LOG_H : 1;
  localparam logic [ADDR_W:0]   HTS_A  = (ADDR_W + 1)'(HALF_TURN_STEPS);
  localparam logic [ADDR_W+1:0] HTS_2A = (ADDR_W + 2)'(2 * HALF_TURN_STEPS);

  // Quarter-wave sine table, entry j = sin(j * pi / (2 * HALF_TURN_STEPS)).
  logic [TRIG_FRAC_BITS-1:0] trig_rom [HALF_TURN_STEPS+1];

  for (genvar j = 0; j <= HALF_TURN_STEPS; j++) begin : g_rom
    localparam logic [63:0] XJ = (64'(j) * PI_Q30) / 64'(2 * HALF_TURN_STEPS);
    assign trig_rom[j] = TRIG_FRAC_BITS'(sine_from_x(XJ, TRIG_FRAC_BITS));
  end

  logic               s1_v_r;
  logic [RANGE_W-1:0] s1_range_r;
  logic [BEAM_W-1:0]  s1_idx_r;
  logic               s1_last_r;

  logic                      s2_v_r;
  beam_stage_t               s2_r;
  beam_stage_t               s2_nxt;
  logic [TRIG_FRAC_BITS-1:0] trig_r;

  logic              s2_free;
  logic              in_ready;
  logic              examined;
  logic              side;
  logic [BEAM_W-1:0] offs;
  logic [BEAM_W-1:0] rem;
  logic [ADDR_W-1:0] mod_q;
  logic [ADDR_W:0]   ang2;
  logic [ADDR_W+1:0] fold_w;
  logic [ADDR_W-1:0] fold;
  logic [ADDR_W-1:0] rom_addr;

  assign s2_free     = !s2_v_r || stg_take;
  assign in_ready    = !s1_v_r || s2_free;
  assign in_beam.ready = in_ready;

  assign examined = (32'(s1_idx_r) < MAX_BEAMS) &&
                    (s1_idx_r >= zone_cfg.index_right) &&
                    (s1_idx_r <= zone_cfg.index_left);
  assign side     = (s1_idx_r < zone_cfg.index_top_right) ||
                    (s1_idx_r >= zone_cfg.index_top_left);
  assign offs     = s1_idx_r - zone_cfg.index_right;

  // offset mod half turn by conditional subtraction of shifted multiples
  always_comb begin
    rem = offs;
    for (int s = MOD_STEPS - 1; s >= 0; s--) begin
      if (32'(rem) >= (HALF_TURN_STEPS << s)) begin
        rem = rem - BEAM_W'(HALF_TURN_STEPS << s);
      end
    end
  end

  // angle folded into the first quarter; cosine reads the mirrored entry
  always_comb begin
    mod_q  = ADDR_W'(rem);
    ang2   = {mod_q, 1'b0};
    fold_w = (ang2 <= HTS_A) ? {1'b0, ang2} : HTS_2A - {1'b0, ang2};
    fold   = fold_w[ADDR_W-1:0];
    rom_addr = side ? ADDR_W'(HTS_A - {1'b0, fold}) : fold;
  end

  always_comb begin
    s2_nxt.range_mm = s1_range_r;
    s2_nxt.limit_mm = side ? zone_cfg.half_width_mm : zone_cfg.depth_mm;
    s2_nxt.check    = examined && (s1_range_r != RANGE_NO_RETURN);
    s2_nxt.last     = s1_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_v_r <= in_beam.valid;
      end
      if (s2_free) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_beam.valid) begin
      s1_range_r <= in_beam.range_mm;
      s1_idx_r   <= in_beam.beam_index;
      s1_last_r  <= in_beam.last_of_scan;
    end
    if (s2_free && s1_v_r) begin
      s2_r   <= s2_nxt;
      trig_r <= trig_rom[rom_addr];
    end
  end

  assign stg_valid = s2_v_r;
  assign stg       = s2_r;
  assign stg_trig  = trig_r;

endmodule

/* sv/lrza_judge.sv */
// Zone compare, per-scan alarm state and the result register.
module lrza_judge #(
  parameter int TRIG_FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      stg_valid,
  input  lrza_pkg::beam_stage_t     stg,
  input  logic [TRIG_FRAC_BITS-1:0] stg_trig,
  output logic                      stg_take,
  lrza_result_if.source             out_result
);
  import lrza_pkg::*;

  localparam int PROD_W = RANGE_W + TRIG_FRAC_BITS;

  logic scan_blocked_r;
  logic prev_alarm_r;
  logic out_v_r;
  logic alarm_r;
  logic estop_r;
  logic clear_r;

  logic              out_free;
  logic              take;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] bound;
  logic              blocks;
  logic              alarm_nxt;

  assign out_free = !out_v_r || out_result.ready;
  // beams that end no scan retire even while a result waits
  assign take     = stg_valid && (!stg.last || out_free);
  assign stg_take = take;

  assign prod      = PROD_W'(stg.range_mm) * PROD_W'(stg_trig);
  assign bound     = {stg.limit_mm, {TRIG_FRAC_BITS{1'b0}}};
  assign blocks    = stg.check && (prod <= bound);
  assign alarm_nxt = scan_blocked_r || blocks;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_blocked_r <= 1'b0;
      prev_alarm_r   <= 1'b0;
      out_v_r        <= 1'b0;
    end else begin
      if (out_result.ready) begin
        out_v_r <= 1'b0;
      end
      if (take) begin
        if (stg.last) begin
          out_v_r        <= 1'b1;
          prev_alarm_r   <= alarm_nxt;
          scan_blocked_r <= 1'b0;
        end else begin
          scan_blocked_r <= alarm_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && stg.last) begin
      alarm_r <= alarm_nxt;
      estop_r <= alarm_nxt && !prev_alarm_r;
      clear_r <= !alarm_nxt && prev_alarm_r;
    end
  end

  assign out_result.valid         = out_v_r;
  assign out_result.alarm         = alarm_r;
  assign out_result.estop_request = estop_r;
  assign out_result.clear_request = clear_r;

endmodule

/* sv/lrza_checker.sv */
// Port-level checker for the zone alarm result channel, bound to the top.
`include "lidar_rect_zone_alarm_top_assert.svh"

module lrza_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic out_alarm,
  input logic out_estop,
  input logic out_clear
);

  `LRZA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
  `LRZA_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable({out_alarm, out_estop, out_clear}))
  `LRZA_ASSERT_IMP(a_estop_alarm, out_valid && out_estop, out_alarm)
  `LRZA_ASSERT_IMP(a_clear_no_alarm, out_valid && out_clear, !out_alarm)

endmodule

bind lidar_rect_zone_alarm_top lrza_checker u_lrza_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_result.valid),
  .out_ready (out_result.ready),
  .out_alarm (out_result.alarm),
  .out_estop (out_result.estop_request),
  .out_clear (out_result.clear_request)
);

/* tb/tb_lidar_rect_zone_alarm_top.sv */
// Testbench for the lidar rectangular zone alarm: directed and random scans checked per verdict.
module tb_lidar_rect_zone_alarm_top;
  import lrza_pkg::*;

  localparam int HALF_STEPS   = 512;
  localparam int FRAC_BITS    = 16;
  localparam int BEAM_LIMIT   = 1024;
  localparam int DRAIN_CYCLES = 6;
  localparam int WATCHDOG     = 5000;
  localparam int HOLD_CYCLES  = 80;
  localparam int PHASE_BEAMS  = 190;

  typedef struct packed {
    logic alarm;
    logic estop;
    logic clear;
  } scan_verdict_t;

  logic clk;
  logic rst_n;

  lrza_beam_if   beam_if ();
  lrza_result_if res_if ();
  lrza_cfg_if    cfg_if ();

  lidar_rect_zone_alarm_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_beam    (beam_if),
    .out_result (res_if),
    .cfg_wr     (cfg_if)
  );

  // Zone model state
  logic [31:0]   sine_lut [0:HALF_STEPS];
  zone_cfg_t     zone_cfg;
  bit            scan_hit;
  bit            prev_alarm;
  scan_verdict_t verdict_q [$];

  bit src_idle_en;
  bit sink_idle_en;
  int sink_hold;
  int fail_count;
  int beams_sent;
  int beams_counted;
  int verdicts_checked;
  int settings_used;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Q0.16 sine of j * pi / (2 * HALF_STEPS), Taylor series in Q2.30
  function automatic logic [31:0] taylor_sine_q(int j);
    logic [63:0]        x;
    logic [63:0]        term;
    logic [63:0]        val;
    logic signed [63:0] acc;
    x    = (64'(j) * PI_Q30) / 64'(2 * HALF_STEPS);
    term = x;
    acc  = signed'(x);
    for (int n = 1; n <= 12; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - signed'(term);
      end else begin
        acc = acc + signed'(term);
      end
    end
    if (acc < 0) begin
      acc = '0;
    end
    val = (unsigned'(acc) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    if (val > (64'd1 << FRAC_BITS) - 64'd1) begin
      val = (64'd1 << FRAC_BITS) - 64'd1;
    end
    return val[31:0];
  endfunction

  function automatic bit zone_blocks(logic [RANGE_W-1:0] r, logic [BEAM_W-1:0] i);
    logic [31:0] k;
    logic [31:0] a;
    logic [31:0] q;
    logic [63:0] tv;
    logic [63:0] lim;
    k = 32'(i) - 32'(zone_cfg.index_right);
    a = 2 * (k % HALF_STEPS);
    q = (a <= HALF_STEPS) ? a : 2 * HALF_STEPS - a;
    if (r == RANGE_NO_RETURN) begin
      return 1'b0;
    end
    if (i < zone_cfg.index_top_right || i >= zone_cfg.index_top_left) begin
      tv  = 64'(sine_lut[HALF_STEPS - q]);
      lim = 64'(zone_cfg.half_width_mm);
    end else begin
      tv  = 64'(sine_lut[q]);
      lim = 64'(zone_cfg.depth_mm);
    end
    return (64'(r) * tv) <= (lim << FRAC_BITS);
  endfunction

  // Fold one accepted beam into the scan; queue a verdict on the last beam.
  function automatic bit account_beam(logic [RANGE_W-1:0] r, logic [BEAM_W-1:0] i, logic last);
    bit            examined;
    scan_verdict_t v;
    examined = (32'(i) < BEAM_LIMIT) && (i >= zone_cfg.index_right) &&
               (i <= zone_cfg.index_left);
    if (examined && zone_blocks(r, i)) begin
      scan_hit = 1'b1;
    end
    if (last) begin
      v.alarm = scan_hit;
      v.estop = scan_hit && !prev_alarm;
      v.clear = !scan_hit && prev_alarm;
      verdict_q.push_back(v);
      prev_alarm = scan_hit;
      scan_hit   = 1'b0;
    end
    return examined || last;
  endfunction

  function automatic void check_field(string name, logic exp_v, logic act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0b, got %0b", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  function automatic logic [RANGE_W-1:0] pick_range(bit hot);
    case ($urandom_range(0, 3))
      0: return RANGE_NO_RETURN;
      1: return 16'($urandom);
      2: return hot ? 16'($urandom_range(0, 3000)) : 16'($urandom_range(20000, 65534));
      default: return hot ? 16'($urandom_range(0, 600)) : RANGE_NO_RETURN;
    endcase
  endfunction

  task automatic offer_beam(logic [RANGE_W-1:0] r, logic [BEAM_W-1:0] i, logic last);
    int gap;
    gap = src_idle_en ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      beam_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    beam_if.valid        <= 1'b1;
    beam_if.range_mm     <= r;
    beam_if.beam_index   <= i;
    beam_if.last_of_scan <= last;
    @(posedge clk);
    while (!beam_if.ready) @(posedge clk);
    beams_sent++;
    if (account_beam(r, i, last)) begin
      beams_counted++;
    end
  endtask

  task automatic wait_idle();
    beam_if.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_zone_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= r;
    cfg_if.data  <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (r)
      REG_HALF_WIDTH:      zone_cfg.half_width_mm   = v;
      REG_DEPTH:           zone_cfg.depth_mm        = v;
      REG_INDEX_RIGHT:     zone_cfg.index_right     = v[BEAM_W-1:0];
      REG_INDEX_TOP_RIGHT: zone_cfg.index_top_right = v[BEAM_W-1:0];
      REG_INDEX_TOP_LEFT:  zone_cfg.index_top_left  = v[BEAM_W-1:0];
      REG_INDEX_LEFT:      zone_cfg.index_left      = v[BEAM_W-1:0];
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_zone(int hw, int dp, int ir, int itr, int itl, int il);
    wait_idle();
    write_zone_reg(REG_HALF_WIDTH, 16'(hw));
    write_zone_reg(REG_DEPTH, 16'(dp));
    write_zone_reg(REG_INDEX_RIGHT, 16'(ir));
    write_zone_reg(REG_INDEX_TOP_RIGHT, 16'(itr));
    write_zone_reg(REG_INDEX_TOP_LEFT, 16'(itl));
    write_zone_reg(REG_INDEX_LEFT, 16'(il));
    settings_used++;
  endtask

  // Mostly consecutive beams from a start inside the window when there is one, some stray indices.
  task automatic send_scan(int n);
    logic [BEAM_W-1:0] idx;
    bit                hot;
    hot = 1'($urandom_range(0, 1));
    if (zone_cfg.index_right <= zone_cfg.index_left) begin
      idx = BEAM_W'($urandom_range(zone_cfg.index_right, zone_cfg.index_left));
    end else begin
      idx = 10'($urandom);
    end
    for (int b = 0; b < n; b++) begin
      if ($urandom_range(0, 9) == 0) begin
        offer_beam(pick_range(hot), 10'($urandom), b == n - 1);
      end else begin
        offer_beam(pick_range(hot), idx, b == n - 1);
      end
      idx = idx + 10'd1;
    end
  endtask

  // Default window covers beam 0 only, in the side region at angle zero.
  task automatic test_reset_defaults();
    offer_beam(16'd500, 10'd0, 1'b1);
    offer_beam(16'd501, 10'd0, 1'b1);
    offer_beam(16'd0, 10'd5, 1'b1);
  endtask

  task automatic test_zone_edges();
    program_zone(500, 2000, 100, 356, 612, 868);
    offer_beam(16'd500, 10'd100, 1'b1);
    offer_beam(RANGE_NO_RETURN, 10'd100, 1'b1);
    offer_beam(16'd0, 10'd99, 1'b1);
    offer_beam(16'd0, 10'd400, 1'b0);
    offer_beam(16'd0, 10'd869, 1'b1);
    offer_beam(16'd2001, 10'd356, 1'b0);
    // angle wraps past a half turn here
    offer_beam(16'd65534, 10'd612, 1'b0);
    offer_beam(16'd65534, 10'd868, 1'b1);
    offer_beam(RANGE_NO_RETURN, 10'd0, 1'b0);
    offer_beam(RANGE_NO_RETURN, 10'd1023, 1'b1);
    offer_beam(16'd0, 10'd1023, 1'b1);
  endtask

  task automatic test_bound_orders();
    // right above left: nothing examined
    program_zone(65535, 65535, 900, 300, 600, 100);
    offer_beam(16'd0, 10'd500, 1'b1);
    // top_right below index_right: window beams below 1023 tested as middle
    program_zone(0, 0, 200, 100, 1023, 1023);
    offer_beam(16'd65534, 10'd200, 1'b1);
  endtask

  task automatic test_output_backpressure();
    bit saved_idle;
    program_zone(800, 1500, 0, 256, 768, 1023);
    saved_idle  = src_idle_en;
    src_idle_en = 1'b0;
    sink_hold   = HOLD_CYCLES;
    for (int n = 0; n < 40; n++) begin
      offer_beam(pick_range(n % 2 == 1), 10'($urandom), 1'($urandom_range(0, 1)));
    end
    offer_beam(pick_range(1'b1), 10'($urandom), 1'b1);
    src_idle_en = saved_idle;
  endtask

  task automatic test_random_scans();
    int ir;
    int itr;
    int itl;
    int il;
    int start;
    int budget;
    bit wide;
    for (int p = 0; p < 10; p++) begin
      wide = 1'($urandom_range(0, 1));
      ir   = $urandom_range(0, 300);
      il   = $urandom_range(700, 1023);
      itr  = $urandom_range(ir, 600);
      itl  = $urandom_range(itr, il);
      case (p)
        0: program_zone(0, 0, 0, itr, itl, 1023);
        1: program_zone(65535, 65535, 0, 0, 1023, 1023);
        2: program_zone($urandom, $urandom, $urandom_range(600, 1023), itr, itl,
                        $urandom_range(0, 500));
        3: program_zone($urandom_range(0, 4000), $urandom_range(0, 4000), 1023, 1023, 1023,
                        1023);
        default: begin
          if (wide) begin
            program_zone($urandom_range(0, 65535), $urandom_range(0, 65535), ir, itr, itl, il);
          end else begin
            program_zone($urandom_range(0, 4000), $urandom_range(0, 4000), ir, itr, itl, il);
          end
        end
      endcase
      src_idle_en  = (p == 4) ? 1'b0 : (p == 0) ? 1'b1 : bit'($urandom_range(0, 1));
      sink_idle_en = (p == 4) ? 1'b0 : (p == 0) ? 1'b1 : bit'($urandom_range(0, 1));
      start  = beams_sent;
      budget = (zone_cfg.index_right <= zone_cfg.index_left) ? PHASE_BEAMS : 40;
      while (beams_sent - start < budget) begin
        send_scan(budget == PHASE_BEAMS ? $urandom_range(1, 24) : $urandom_range(1, 4));
      end
    end
  endtask

  // Result sink: random stalls, one long hold on request, check per transaction.
  initial begin : result_sink
    int            stall;
    scan_verdict_t exp_v;
    res_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = sink_idle_en ? $urandom_range(0, 4) : 0;
      if (sink_hold > 0) begin
        stall     = sink_hold;
        sink_hold = 0;
      end
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      @(posedge clk);
      while (!res_if.valid) @(posedge clk);
      if (verdict_q.size() == 0) begin
        $error("result transaction with no scan pending");
        fail_count++;
      end else begin
        exp_v = verdict_q.pop_front();
        check_field("alarm", exp_v.alarm, res_if.alarm);
        check_field("estop_request", exp_v.estop, res_if.estop_request);
        check_field("clear_request", exp_v.clear, res_if.clear_request);
        verdicts_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((beam_if.valid && beam_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin : test_sequence
    beam_if.valid        <= 1'b0;
    beam_if.range_mm     <= '0;
    beam_if.beam_index   <= '0;
    beam_if.last_of_scan <= 1'b0;
    cfg_if.valid         <= 1'b0;
    cfg_if.index         <= REG_HALF_WIDTH;
    cfg_if.data          <= '0;
    rst_n                <= 1'b0;
    quiet_cycles = 0;
    fail_count   = 0;
    sink_hold    = 0;
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    for (int j = 0; j <= HALF_STEPS; j++) begin
      sine_lut[j] = taylor_sine_q(j);
    end
    zone_cfg.half_width_mm   = HALF_WIDTH_RST;
    zone_cfg.depth_mm        = DEPTH_RST;
    zone_cfg.index_right     = '0;
    zone_cfg.index_top_right = '0;
    zone_cfg.index_top_left  = '0;
    zone_cfg.index_left      = '0;
    scan_hit   = 1'b0;
    prev_alarm = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_zone_edges();
    test_bound_orders();
    test_output_backpressure();
    test_random_scans();
    wait_idle();

    $display("Sent %0d beams (%0d examined or scan-ending), checked %0d scan verdicts",
             beams_sent, beams_counted, verdicts_checked);
    $display("under %0d zone settings, with random stalls on both sides and one long hold.",
             settings_used);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* lidar_rect_zone_alarm_top.f */
+incdir+sv
sv/lrza_pkg.sv
sv/lrza_if.sv
sv/lrza_cfg_regs.sv
sv/lrza_front.sv
sv/lrza_judge.sv
sv/lidar_rect_zone_alarm_top.sv
sv/lrza_checker.sv
tb/tb_lidar_rect_zone_alarm_top.sv
